### rtl/core/sal_pkg.sv
// Shared types and constants for the scroll axis-lock filter.
// No dependencies; used by scroll_axis_lock_filter and its testbench.
`default_nettype none
package sal_pkg;

  typedef struct packed {
    logic               start_scroll;
    logic signed [15:0] delta_x_q8;
    logic signed [15:0] delta_y_q8;
    logic [47:0]        stamp_us;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_x_q8;
    logic signed [15:0] out_y_q8;
    logic               horiz_on;
    logic               vert_on;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_NUM,
    ST_MUL,
    ST_RCP,
    ST_QT,
    ST_REM,
    ST_FIX,
    ST_PROD,
    ST_DWELL,
    ST_LOCK,
    ST_DONE
  } state_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_DWELL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INACTIVE_DWELL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_HORIZ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VERT   = 3'd3;

  localparam logic [19:0] RST_ACTIVE_DWELL   = 20'd100000;
  localparam logic [19:0] RST_INACTIVE_DWELL = 20'd50000;
  localparam logic [15:0] RST_INITIAL_HORIZ  = 16'd38;
  localparam logic [15:0] RST_INITIAL_VERT   = 16'd26;

  // squared-length gates in Q16 mm^2
  localparam logic [63:0] LEN_MIN_SQ  = 64'd1474;
  localparam logic [63:0] LEN_DIAG_SQ = 64'd1638400;

  // slope band coefficients, scaled by 100
  localparam logic [31:0] K_100 = 32'd100;
  localparam logic [31:0] K_057 = 32'd57;
  localparam logic [31:0] K_173 = 32'd173;
  localparam logic [31:0] K_373 = 32'd373;
  localparam logic [31:0] K_027 = 32'd27;

  // product steps of the shared multiplier
  localparam logic [2:0] OP_SQX  = 3'd0;
  localparam logic [2:0] OP_SQY  = 3'd1;
  localparam logic [2:0] OP_Y100 = 3'd2;
  localparam logic [2:0] OP_X057 = 3'd3;
  localparam logic [2:0] OP_X173 = 3'd4;
  localparam logic [2:0] OP_X373 = 3'd5;
  localparam logic [2:0] OP_X027 = 3'd6;
  localparam logic [2:0] OP_END  = 3'd7;

endpackage
`default_nettype wire

### rtl/core/sal_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on nothing; instanced by scroll_axis_lock_filter.
`default_nettype none
module sal_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule
`default_nettype wire

### rtl/core/sal_div.sv
// Divide by a constant: reciprocal estimate from products of the shared
// multiplier, then a short remainder correction. Depends on nothing.
`default_nettype none
module sal_div #(
  parameter int DIVISOR = 100000,
  parameter int SH      = 17
) (
  input  wire logic        clk,
  input  wire logic        load_n,
  input  wire logic        load_q,
  input  wire logic        load_r,
  input  wire logic        fix,
  input  wire logic [63:0] p,
  output logic      [31:0] nh,
  output logic      [31:0] q_est,
  output logic             more,
  output logic      [31:0] quotient
);

  // estimate is at most three below the true quotient, so rem < 4*DIVISOR
  localparam int RW = SH + 3;
  localparam logic [RW-1:0] DIV_V = RW'(DIVISOR);

  logic [SH+31:0] n;
  logic [SH+31:0] r_full;
  logic [RW-1:0]  rem;

  assign nh     = p[SH+31:SH];
  assign q_est  = p[62:31];
  assign r_full = n - p[SH+31:0];
  assign more   = rem >= DIV_V;

  always_ff @(posedge clk) begin
    if (load_n) n <= p[SH+31:0];
    if (load_q) quotient <= q_est;
    else if (fix && more) quotient <= quotient + 32'd1;
    if (load_r) rem <= r_full[RW-1:0];
    else if (fix && more) rem <= rem - DIV_V;
  end

endmodule
`default_nettype wire

### rtl/core/scroll_axis_lock_filter.sv
// Scroll axis-lock filter top level: sequencer, state and config registers.
// Depends on sal_pkg, sal_mul and sal_div.
//
//  channel  signals                       direction  beat
//  in       in_valid/in_ready/in_data     input      one scroll motion event
//  out      out_valid/out_ready/out_data  output     filtered delta and axis flags
//  cfg      cfg_we/cfg_index/cfg_data     input      one register write
//
// From accept to the next accept, the sequencer runs per axis a
// divide by the timeout (multiply, reciprocal multiply, back-multiply,
// remainder, up to three correction steps), then eight product steps; it skips
// to the output step once both axes are free-scrolling. One event at a time;
// in_ready is low while busy. The output register holds a result while the next
// event runs; a stalled output holds the sequencer at its last step. Sync reset
// restores register defaults and clears the scroll state.
`default_nettype none
module scroll_axis_lock_filter #(
  parameter int EVENT_TIMEOUT_US = 100000
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire sal_pkg::in_beat_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output sal_pkg::out_beat_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [sal_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sal_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int EL_W = $clog2(EVENT_TIMEOUT_US + 1);
  localparam int SH   = $clog2(EVENT_TIMEOUT_US);
  localparam logic [EL_W-1:0] TIMEOUT  = EL_W'(EVENT_TIMEOUT_US);
  localparam logic [EL_W-1:0] EL_KNEE  = EL_W'((33 * EVENT_TIMEOUT_US) / 100);
  localparam logic [31:0] TIMEOUT_OP = 32'(EVENT_TIMEOUT_US);
  // 2^(SH+31)/T fits 32 bits since T > 2^(SH-1)
  localparam logic [31:0] RECIP = 32'((64'd1 << (SH + 31)) / 64'(EVENT_TIMEOUT_US));

  sal_pkg::state_t state, state_next;

  logic [19:0] active_dwell, inactive_dwell;
  logic [15:0] initial_horiz, initial_vert;

  sal_pkg::in_beat_t ev;
  logic signed [31:0] vec_x, vec_y;
  logic [47:0] last_stamp;
  logic [19:0] dwell_horiz, dwell_vert;
  logic        horiz_active, vert_active;

  logic [EL_W-1:0] el, num;
  logic [2:0]  step;
  logic        on_y;
  logic [63:0] sqx, lensq, c100;
  logic        ge057, lt173, ge373, lt027;
  logic signed [15:0] res_x, res_y;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] div_nh, div_qe, div_q;
  logic        div_more;
  logic [31:0] ax, ay;
  logic [47:0] diff;

  assign ax   = vec_x[31] ? 32'(-vec_x) : 32'(vec_x);
  assign ay   = vec_y[31] ? 32'(-vec_y) : 32'(vec_y);
  assign diff = ev.stamp_us - last_stamp;

  sal_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  sal_div #(.DIVISOR(EVENT_TIMEOUT_US), .SH(SH)) u_div (
    .clk(clk),
    .load_n(state == sal_pkg::ST_RCP), .load_q(state == sal_pkg::ST_QT),
    .load_r(state == sal_pkg::ST_REM), .fix(state == sal_pkg::ST_FIX),
    .p(mul_p), .nh(div_nh), .q_est(div_qe), .more(div_more), .quotient(div_q)
  );

  function automatic logic signed [31:0] sat_add(input logic neg, input logic [31:0] q,
                                                 input logic signed [15:0] d);
    logic signed [33:0] qs, s;
    qs = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    s  = qs + 34'(d);
    if (s > 34'sd2147483647) sat_add = 32'sh7fffffff;
    else if (s < -34'sd2147483648) sat_add = 32'sh80000000;
    else sat_add = s[31:0];
  endfunction

  function automatic logic [19:0] grow(input logic [19:0] dw, input logic [19:0] act,
                                       input logic [EL_W-1:0] e);
    logic [20:0] s;
    s = {1'b0, dw} + 21'(e);
    grow = (s > {1'b0, act}) ? act : s[19:0];
  endfunction

  function automatic logic [19:0] shrink(input logic [19:0] dw, input logic [EL_W-1:0] e);
    shrink = (dw > 20'(e)) ? dw - 20'(e) : 20'd0;
  endfunction

  // shared multiplier operand select
  always_comb begin
    mul_a = ax;
    mul_b = 32'(num);
    case (state)
      sal_pkg::ST_MUL: begin mul_a = on_y ? ay : ax; mul_b = 32'(num); end
      sal_pkg::ST_RCP: begin mul_a = div_nh; mul_b = RECIP; end
      sal_pkg::ST_QT:  begin mul_a = div_qe; mul_b = TIMEOUT_OP; end
      sal_pkg::ST_PROD: begin
        case (step)
          sal_pkg::OP_SQX:  begin mul_a = ax; mul_b = ax; end
          sal_pkg::OP_SQY:  begin mul_a = ay; mul_b = ay; end
          sal_pkg::OP_Y100: begin mul_a = ay; mul_b = sal_pkg::K_100; end
          sal_pkg::OP_X057: begin mul_a = ax; mul_b = sal_pkg::K_057; end
          sal_pkg::OP_X173: begin mul_a = ax; mul_b = sal_pkg::K_173; end
          sal_pkg::OP_X373: begin mul_a = ax; mul_b = sal_pkg::K_373; end
          sal_pkg::OP_X027: begin mul_a = ax; mul_b = sal_pkg::K_027; end
          default:          begin mul_a = ax; mul_b = ax; end
        endcase
      end
      default: ;
    endcase
  end

  assign in_ready = (state == sal_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= sal_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      sal_pkg::ST_IDLE:    if (in_valid) state_next = sal_pkg::ST_ELAPSED;
      sal_pkg::ST_ELAPSED: state_next = (horiz_active && vert_active) ?
                                        sal_pkg::ST_DONE : sal_pkg::ST_NUM;
      sal_pkg::ST_NUM:     state_next = sal_pkg::ST_MUL;
      sal_pkg::ST_MUL:     state_next = sal_pkg::ST_RCP;
      sal_pkg::ST_RCP:     state_next = sal_pkg::ST_QT;
      sal_pkg::ST_QT:      state_next = sal_pkg::ST_REM;
      sal_pkg::ST_REM:     state_next = sal_pkg::ST_FIX;
      sal_pkg::ST_FIX:     if (!div_more) state_next = on_y ? sal_pkg::ST_PROD :
                                                              sal_pkg::ST_MUL;
      sal_pkg::ST_PROD:    if (step == sal_pkg::OP_END) state_next = sal_pkg::ST_DWELL;
      sal_pkg::ST_DWELL:   state_next = sal_pkg::ST_LOCK;
      sal_pkg::ST_LOCK:    state_next = sal_pkg::ST_DONE;
      sal_pkg::ST_DONE:    if (!out_valid || out_ready) state_next = sal_pkg::ST_IDLE;
      default:             state_next = sal_pkg::ST_IDLE;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_dwell   <= sal_pkg::RST_ACTIVE_DWELL;
      inactive_dwell <= sal_pkg::RST_INACTIVE_DWELL;
      initial_horiz  <= sal_pkg::RST_INITIAL_HORIZ;
      initial_vert   <= sal_pkg::RST_INITIAL_VERT;
    end else if (cfg_we) begin
      case (cfg_index)
        sal_pkg::CFG_ACTIVE_DWELL:   active_dwell   <= cfg_data;
        sal_pkg::CFG_INACTIVE_DWELL: inactive_dwell <= cfg_data;
        sal_pkg::CFG_INITIAL_HORIZ:  initial_horiz  <= cfg_data[15:0];
        sal_pkg::CFG_INITIAL_VERT:   initial_vert   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // scroll state and sequencer datapath
  always_ff @(posedge clk) begin
    logic        h0, v0, h1, v1;
    logic [19:0] dh, dv;
    if (rst) begin
      vec_x        <= '0;
      vec_y        <= '0;
      last_stamp   <= '0;
      dwell_horiz  <= '0;
      dwell_vert   <= '0;
      horiz_active <= 1'b0;
      vert_active  <= 1'b0;
      out_valid    <= 1'b0;
      step         <= '0;
      on_y         <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != sal_pkg::ST_DONE) out_valid <= 1'b0;
      case (state)
        sal_pkg::ST_IDLE: begin
          if (in_valid) begin
            ev <= in_data;
            if (in_data.start_scroll) begin
              vec_x        <= '0;
              vec_y        <= '0;
              last_stamp   <= '0;
              dwell_horiz  <= '0;
              dwell_vert   <= '0;
              horiz_active <= 1'b0;
              vert_active  <= 1'b0;
            end
          end
        end
        sal_pkg::ST_ELAPSED: begin
          res_x <= ev.delta_x_q8;
          res_y <= ev.delta_y_q8;
          el    <= (last_stamp != '0 && diff <= 48'(TIMEOUT)) ? diff[EL_W-1:0] : '0;
        end
        sal_pkg::ST_NUM: begin
          last_stamp <= ev.stamp_us;
          if (el == '0)          num <= '0;
          else if (el <= EL_KNEE) num <= TIMEOUT - EL_W'({el, 1'b0});
          else                    num <= TIMEOUT - el;
          step <= '0;
          on_y <= 1'b0;
        end
        sal_pkg::ST_FIX: begin
          if (!div_more) begin
            if (on_y) vec_y <= sat_add(vec_y[31], div_q, ev.delta_y_q8);
            else      vec_x <= sat_add(vec_x[31], div_q, ev.delta_x_q8);
            on_y <= ~on_y;
          end
        end
        sal_pkg::ST_PROD: begin
          step <= step + 1'b1;
          // product of the previous step is on mul_p now
          case (step)
            sal_pkg::OP_SQY:  sqx   <= mul_p;
            sal_pkg::OP_Y100: lensq <= sqx + mul_p;
            sal_pkg::OP_X057: c100  <= mul_p;
            sal_pkg::OP_X173: ge057 <= c100 >= mul_p;
            sal_pkg::OP_X373: lt173 <= c100 <  mul_p;
            sal_pkg::OP_X027: ge373 <= c100 >= mul_p;
            sal_pkg::OP_END:  lt027 <= c100 <  mul_p;
            default: ;
          endcase
        end
        sal_pkg::ST_DWELL: begin
          h0 = horiz_active;
          v0 = vert_active;
          if (!h0 && !v0) begin
            h0 = ax > 32'(initial_horiz);
            v0 = ay > 32'(initial_vert);
          end
          dh = dwell_horiz;
          dv = dwell_vert;
          if (lensq > sal_pkg::LEN_MIN_SQ) begin
            if (ge057) begin
              dv = grow(dv, active_dwell, el);
              if (ge373) dh = shrink(dh, el);
            end
            if (lt173) begin
              dh = grow(dh, active_dwell, el);
              if (lt027) dv = shrink(dv, el);
            end
          end
          dwell_horiz  <= dh;
          dwell_vert   <= dv;
          horiz_active <= h0;
          vert_active  <= v0;
        end
        sal_pkg::ST_LOCK: begin
          h1 = horiz_active;
          v1 = vert_active;
          if (dwell_horiz == active_dwell) begin
            h1 = 1'b1;
            if (dwell_vert < inactive_dwell) v1 = 1'b0;
          end
          if (dwell_vert == active_dwell) begin
            v1 = 1'b1;
            if (dwell_horiz < inactive_dwell) h1 = 1'b0;
          end
          if (lensq > sal_pkg::LEN_DIAG_SQ && lt173 && ge057) begin
            h1 = 1'b1;
            v1 = 1'b1;
          end
          horiz_active <= h1;
          vert_active  <= v1;
          if (!h1 && v1) res_x <= '0;
          if (h1 && !v1) res_y <= '0;
        end
        sal_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            out_data.out_x_q8 <= res_x;
            out_data.out_y_q8 <= res_y;
            out_data.horiz_on <= horiz_active;
            out_data.vert_on  <= vert_active;
          end
        end
        default: ;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second event while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_horiz_lock_zeroes_y: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.horiz_on && !out_data.vert_on |-> out_data.out_y_q8 == '0)
    else $error("vertical delta leaked while locked horizontal");

  a_vert_lock_zeroes_x: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.horiz_on && out_data.vert_on |-> out_data.out_x_q8 == '0)
    else $error("horizontal delta leaked while locked vertical");

endmodule
`default_nettype wire

### verif/scroll_axis_lock_filter_test.sv
// Self-checking testbench for the scroll axis-lock filter.
// Depends on sal_pkg and the scroll_axis_lock_filter RTL; predicts every beat in-line.
`timescale 1ns / 1ps
module scroll_axis_lock_filter_test;

  localparam int TIMEOUT_US = 100000;
  localparam logic [sal_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd6;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  sal_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  sal_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [sal_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sal_pkg::CFG_DATA_W-1:0] cfg_data;

  scroll_axis_lock_filter uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and scroll state
  logic [19:0] p_active_dwell, p_inactive_dwell;
  logic [15:0] p_init_h, p_init_v;
  logic signed [31:0] p_vx, p_vy;
  logic [47:0] p_last;
  logic [19:0] p_dw_h, p_dw_v;
  logic p_h_on, p_v_on;

  sal_pkg::out_beat_t expected_beats[$];
  int errors = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int hold_off = 0;          // receiver hold-off in cycles
  logic [47:0] clock_us;     // running stamp generator

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout at %0t", $time);
    $display("status: fail");
    $finish;
  end

  function automatic logic signed [31:0] decay_sum(logic signed [31:0] v, longint num,
                                                  logic signed [15:0] d);
    longint s;
    s = (longint'(v) * num) / TIMEOUT_US + longint'(d);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic logic [19:0] dwell_up(logic [19:0] dw, logic [31:0] e);
    longint s;
    s = longint'(dw) + longint'(e);
    if (s > longint'(p_active_dwell)) s = longint'(p_active_dwell);
    return s[19:0];
  endfunction

  function automatic logic [19:0] dwell_down(logic [19:0] dw, logic [31:0] e);
    return (32'(dw) > e) ? dw - e[19:0] : 20'd0;
  endfunction

  task automatic clear_scroll_state();
    p_vx = 0; p_vy = 0; p_last = 0;
    p_dw_h = 0; p_dw_v = 0; p_h_on = 0; p_v_on = 0;
  endtask

  function automatic longint mag(logic signed [31:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  task automatic predict_filter(input sal_pkg::in_beat_t b);
    sal_pkg::out_beat_t r;
    logic [47:0] el48;
    logic [31:0] el;
    longint num, ax, ay, lensq;
    logic ge057, lt173, ge373, lt027;
    r.out_x_q8 = b.delta_x_q8;
    r.out_y_q8 = b.delta_y_q8;
    if (b.start_scroll) clear_scroll_state();
    if (!(p_h_on && p_v_on)) begin
      el48 = (p_last != 0) ? b.stamp_us - p_last : 48'd0;
      if (el48 > TIMEOUT_US) el48 = 0;
      el = el48[31:0];
      p_last = b.stamp_us;
      if (el == 0) num = 0;
      else if (100 * longint'(el) <= 33 * longint'(TIMEOUT_US))
        num = longint'(TIMEOUT_US) - 2 * longint'(el);
      else num = longint'(TIMEOUT_US) - longint'(el);
      p_vx = decay_sum(p_vx, num, b.delta_x_q8);
      p_vy = decay_sum(p_vy, num, b.delta_y_q8);
      ax = mag(p_vx);
      ay = mag(p_vy);
      lensq = ax * ax + ay * ay;  // wraps negative only at 2^63
      if (!p_h_on && !p_v_on) begin
        p_h_on = ax > longint'(p_init_h);
        p_v_on = ay > longint'(p_init_v);
      end
      ge057 = 100 * ay >= 57 * ax;
      lt173 = 100 * ay < 173 * ax;
      ge373 = 100 * ay >= 373 * ax;
      lt027 = 100 * ay < 27 * ax;
      if (lensq < 0 || lensq > 1474) begin
        if (ge057) begin
          p_dw_v = dwell_up(p_dw_v, el);
          if (ge373) p_dw_h = dwell_down(p_dw_h, el);
        end
        if (lt173) begin
          p_dw_h = dwell_up(p_dw_h, el);
          if (lt027) p_dw_v = dwell_down(p_dw_v, el);
        end
      end
      if (p_dw_h == p_active_dwell) begin
        p_h_on = 1;
        if (p_dw_v < p_inactive_dwell) p_v_on = 0;
      end
      if (p_dw_v == p_active_dwell) begin
        p_v_on = 1;
        if (p_dw_h < p_inactive_dwell) p_h_on = 0;
      end
      if ((lensq < 0 || lensq > 1638400) && lt173 && ge057) begin
        p_h_on = 1; p_v_on = 1;
      end
      if (!p_h_on && p_v_on) r.out_x_q8 = 0;
      if (p_h_on && !p_v_on) r.out_y_q8 = 0;
    end
    r.horiz_on = p_h_on;
    r.vert_on = p_v_on;
    expected_beats.push_back(r);
  endtask

  // one input beat; valid stays up into the next call when it has no gap
  task automatic send_event(input logic start, input logic signed [15:0] dx,
                            input logic signed [15:0] dy, input logic [47:0] stamp,
                            input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13)));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{start_scroll: start, delta_x_q8: dx, delta_y_q8: dy, stamp_us: stamp};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_filter('{start, dx, dy, stamp});
    beats_sent++;
  endtask

  // timestamps advance by a random step, sometimes beyond the timeout
  task automatic next_stamp(output logic [47:0] s);
    case ($urandom_range(0, 9))
      0: clock_us += 48'($urandom_range(100001, 400000));
      1: clock_us += 48'($urandom_range(30000, 100000));
      default: clock_us += 48'($urandom_range(1, 30000));
    endcase
    s = clock_us;
  endtask

  // stop offering and wait until every expected result is back
  task automatic wait_drained();
    in_valid <= 0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sal_pkg::CFG_IDX_W-1:0] idx,
                           input logic [19:0] val);
    wait_drained();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      sal_pkg::CFG_ACTIVE_DWELL: p_active_dwell = val;
      sal_pkg::CFG_INACTIVE_DWELL: p_inactive_dwell = val;
      sal_pkg::CFG_INITIAL_HORIZ: p_init_h = val[15:0];
      sal_pkg::CFG_INITIAL_VERT: p_init_v = val[15:0];
      default: ;
    endcase
  endtask

  // receiver: random per-beat wait, plus a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 0;
      end else begin
        if (out_valid && out_ready) stall = int'($urandom_range(0, 13));
        else if (stall > 0) stall--;
        out_ready <= (stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected beat %p", $time, out_data);
        errors++;
      end else begin
        sal_pkg::out_beat_t e;
        e = expected_beats.pop_front();
        beats_checked++;
        if (out_data.out_x_q8 !== e.out_x_q8) begin
          $display("%0t out_x_q8 exp %0d got %0d", $time, e.out_x_q8, out_data.out_x_q8);
          errors++;
        end
        if (out_data.out_y_q8 !== e.out_y_q8) begin
          $display("%0t out_y_q8 exp %0d got %0d", $time, e.out_y_q8, out_data.out_y_q8);
          errors++;
        end
        if (out_data.horiz_on !== e.horiz_on) begin
          $display("%0t horiz_on exp %b got %b", $time, e.horiz_on, out_data.horiz_on);
          errors++;
        end
        if (out_data.vert_on !== e.vert_on) begin
          $display("%0t vert_on exp %b got %b", $time, e.vert_on, out_data.vert_on);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_event(1, 16'sh7fff, 16'sh8000, 48'd1);
    send_event(0, 16'sh8000, 16'sh7fff, 48'd2);
    send_event(1, 0, 0, 48'd0);                 // zero stamp: no previous event
    send_event(0, 16'sd40, 0, 48'd0);
    send_event(0, 16'sd40, 0, 48'hffff_ffff_ffff);
    send_event(0, 16'sd10, 16'sd1, 48'h1000);   // stamp wraps: small diff, decay applies
    send_event(1, 16'sd5, 16'sd2, 48'd5000);
    send_event(0, 16'sd5, 16'sd2, 48'd20000);
    send_event(0, 16'sd5, 16'sd2, 48'd60000);
    send_event(0, 16'sd5, 16'sd2, 48'd120000);   // elapsed above the knee, below timeout
    send_event(0, 16'sd5, 16'sd2, 48'd90000);    // time backwards
    send_event(1, 16'sd2000, 16'sd2000, 48'd7);  // diagonal unlock
    send_event(0, 16'sd3, -16'sd9, 48'd9);       // free scrolling
    send_event(1, 0, -16'sd30, 48'd100);
    send_event(0, 0, -16'sd30, 48'd33100);
    send_event(0, 16'sd1, -16'sd30, 48'd66100);
    send_event(0, 16'sd1, -16'sd30, 48'd99200);
    send_event(0, -16'sd38, 16'sd26, 48'd99300);
    send_event(1, -16'sd39, 16'sd27, 48'd99400);
  endtask

  // well-formed gestures of random length, axis bias and step
  task automatic test_random(input int n_events);
    int i, len, kind;
    logic [47:0] s;
    logic signed [15:0] dx, dy;
    i = 0;
    while (i < n_events) begin
      len = int'($urandom_range(1, 20));
      kind = int'($urandom_range(0, 5));
      for (int k = 0; k < len && i < n_events; k++) begin
        next_stamp(s);
        case (kind)
          0: begin
            dx = 16'($urandom_range(0, 200) - 100);
            dy = 16'($urandom_range(0, 8) - 4);
          end
          1: begin
            dx = 16'($urandom_range(0, 8) - 4);
            dy = 16'($urandom_range(0, 200) - 100);
          end
          2: begin dx = 16'($urandom_range(0, 600) - 300); dy = dx; end
          3: begin dx = 16'($urandom); dy = 16'($urandom); end
          default: begin
            dx = 16'($urandom_range(0, 60) - 30);
            dy = 16'($urandom_range(0, 60) - 30);
          end
        endcase
        if ($urandom_range(0, 40) == 0)
          s = ($urandom_range(0, 3) != 0) ? 48'({$urandom, $urandom}) : 48'd0;
        send_event(k == 0, dx, dy, s);
        i++;
      end
    end
  endtask

  task automatic test_backpressure();
    logic [47:0] s;
    wait_drained();
    hold_off = 600;
    for (int k = 0; k < 6; k++) begin
      next_stamp(s);
      send_event(k == 0, 16'sd50, 16'sd3, s, 1);
    end
    wait_drained();  // sender pause until all results are back
  endtask

  task automatic test_configs();
    write_reg(sal_pkg::CFG_ACTIVE_DWELL, 20'd1);
    write_reg(sal_pkg::CFG_INACTIVE_DWELL, 20'd0);
    write_reg(sal_pkg::CFG_INITIAL_HORIZ, 20'd0);
    write_reg(sal_pkg::CFG_INITIAL_VERT, 20'd0);
    test_random(200);
    write_reg(sal_pkg::CFG_ACTIVE_DWELL, 20'd1000000);
    write_reg(sal_pkg::CFG_INACTIVE_DWELL, 20'd1000000);
    write_reg(sal_pkg::CFG_INITIAL_HORIZ, 20'd65535);
    write_reg(sal_pkg::CFG_INITIAL_VERT, 20'd65535);
    test_random(200);
    write_reg(sal_pkg::CFG_ACTIVE_DWELL, 20'd0);  // dwells pinned at zero
    test_random(150);
    write_reg(sal_pkg::CFG_ACTIVE_DWELL, 20'hfffff);
    write_reg(sal_pkg::CFG_INACTIVE_DWELL, 20'd30000);
    write_reg(sal_pkg::CFG_INITIAL_HORIZ, 20'hffff0);
    write_reg(sal_pkg::CFG_INITIAL_VERT, 20'd10);
    test_random(150);
    write_reg(sal_pkg::CFG_ACTIVE_DWELL, 20'd20000);  // dwells may sit above ceiling
    test_random(100);
    write_reg(CFG_UNMAPPED, 20'd12345);
  endtask

  initial begin
    int waited;
    rst = 1; in_valid = 0; in_data = '0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    clock_us = 48'd1000;
    p_active_dwell = sal_pkg::RST_ACTIVE_DWELL;
    p_inactive_dwell = sal_pkg::RST_INACTIVE_DWELL;
    p_init_h = sal_pkg::RST_INITIAL_HORIZ; p_init_v = sal_pkg::RST_INITIAL_VERT;
    clear_scroll_state();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(330);
    test_configs();
    write_reg(sal_pkg::CFG_ACTIVE_DWELL, sal_pkg::RST_ACTIVE_DWELL);
    test_random(50);
    in_valid <= 0;
    waited = 0;
    while (expected_beats.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0t %0d results never arrived", $time, expected_beats.size());
      errors++;
    end
    $display("Sent %0d events across several register settings and checked %0d results.",
             beats_sent, beats_checked);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
